[sv/ffha_pkg.sv]
// Shared types for the first-fit heap allocator.
package ffha_pkg;

	typedef enum logic [1:0] {
		ALU_ADDH = 2'd0,
		ALU_SUB  = 2'd1,
		ALU_SUBH = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic len_we;
		logic free_we;
		logic free_val;
	} ffha_wr_t;

endpackage

[sv/ffha_alu.sv]
// Shared add/subtract unit with optional header-size term.
module ffha_alu import ffha_pkg::*; #(
	parameter int W      = 15,
	parameter int HEADER = 16
) (
	input  alu_op_t        op,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [W-1:0]   y
);

	localparam logic [W-1:0] HDR = W'(HEADER);

	always_comb begin
		case (op)
			ALU_ADDH: y = a + b + HDR;
			ALU_SUB:  y = a - b;
			ALU_SUBH: y = a - b - HDR;
			default:  y = '0;
		endcase
	end

endmodule

[sv/ffha_store.sv]
// Header store: block length and free flag per heap offset, registered read.
module ffha_store import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(HEAP_BYTES)-1:0] raddr,
	output logic [$clog2(HEAP_BYTES)-1:0] rd_len,
	output logic                          rd_free,
	input  ffha_wr_t                      wr,
	input  logic [$clog2(HEAP_BYTES)-1:0] waddr,
	input  logic [$clog2(HEAP_BYTES)-1:0] wlen
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam logic [AW-1:0] INIT_LEN = AW'(HEAP_BYTES - HEADER_BYTES);

	logic [AW-1:0] len_mem [HEAP_BYTES];
	logic          free_mem [HEAP_BYTES];

	logic [AW-1:0] rlen_q;
	logic          rfree_q;
	logic          rzero_q;
	logic          fresh_len_q;
	logic          fresh_free_q;

	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[waddr] <= wlen;
		end
		if (wr.free_we) begin
			free_mem[waddr] <= wr.free_val;
		end
		rlen_q  <= len_mem[raddr];
		rfree_q <= free_mem[raddr];
		rzero_q <= (raddr == '0);
	end

	// offset 0 holds the initial block until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_len_q  <= 1'b1;
			fresh_free_q <= 1'b1;
		end else begin
			if (wr.len_we && waddr == '0) begin
				fresh_len_q <= 1'b0;
			end
			if (wr.free_we && waddr == '0) begin
				fresh_free_q <= 1'b0;
			end
		end
	end

	assign rd_len  = (rzero_q && fresh_len_q) ? INIT_LEN : rlen_q;
	assign rd_free = (rzero_q && fresh_free_q) ? 1'b1 : rfree_q;

endmodule

[sv/first_fit_heap_allocator_core.sv]
// First-fit heap allocator: sequencer walking block headers through one shared adder.
// Allocate: size the request, then read, evaluate and advance per block header visited;
// stop on a zero-length header or at the heap end, or take a fitting block whole or split it.
// Free: marks the header before the address free. in_ready rises in the same cycle as out_valid; one word in flight.
// A finished result waits in the output register while the next word is accepted.
// Reset (arst_n low) clears the sequencer and output valid; heap is one free block at offset 0.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [12:0] request_size,
	input  logic [11:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [11:0] data_offset
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int PW = AW + 1;
	localparam int DW = (PW > 14) ? PW : 14;
	localparam int W  = DW + 1;
	localparam logic [W-1:0] HEAP_W  = W'(HEAP_BYTES);
	localparam logic [W-1:0] LAST_HD = W'(HEAP_BYTES - HEADER_BYTES);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_NEED = 10'b0000000010,
		S_RD   = 10'b0000000100,
		S_EV   = 10'b0000001000,
		S_ADV  = 10'b0000010000,
		S_SPL  = 10'b0000100000,
		S_NXT  = 10'b0001000000,
		S_WRP  = 10'b0010000000,
		S_FREE = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t        state_q;
	logic [PW-1:0] pos_q;
	logic [DW-1:0] need_q;
	logic [AW-1:0] len_q;
	logic [AW-1:0] rem_q;
	logic          split_q;
	logic [11:0]   addr_q;
	logic [12:0]   req_q;
	logic          res_ok_q;
	logic [11:0]   res_off_q;
	logic          out_valid_q;
	logic          ok_q;
	logic [11:0]   data_offset_q;

	alu_op_t       alu_op;
	logic [W-1:0]  alu_a;
	logic [W-1:0]  alu_b;
	logic [W-1:0]  alu_y;
	logic          neg;

	logic [AW-1:0] rd_len;
	logic          rd_free;
	ffha_wr_t      wr;
	logic [AW-1:0] waddr;
	logic [AW-1:0] wlen;

	ffha_alu #(.W(W), .HEADER(HEADER_BYTES)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	ffha_store #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr   (pos_q[AW-1:0]),
		.rd_len  (rd_len),
		.rd_free (rd_free),
		.wr      (wr),
		.waddr   (waddr),
		.wlen    (wlen)
	);

	assign neg = alu_y[W-1];

	always_comb begin
		alu_op = ALU_ADDH;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_NEED: begin
				alu_a = W'(req_q);
			end
			S_EV: begin
				alu_op = ALU_SUB;
				alu_a  = W'(rd_len);
				alu_b  = W'(need_q);
			end
			S_ADV: begin
				alu_a = W'(pos_q);
				alu_b = W'(len_q);
			end
			S_SPL: begin
				alu_op = ALU_SUBH;
				alu_a  = W'(len_q);
				alu_b  = W'(need_q);
			end
			S_NXT: begin
				alu_a = W'(pos_q);
				alu_b = W'(need_q);
			end
			S_WRP: begin
				alu_a = W'(pos_q);
			end
			S_FREE: begin
				alu_op = ALU_SUBH;
				alu_a  = W'(addr_q);
			end
			default: begin
				alu_op = ALU_ADDH;
			end
		endcase
	end

	always_comb begin
		wr    = '0;
		waddr = alu_y[AW-1:0];
		wlen  = rem_q;
		case (state_q)
			S_NXT: begin
				if (alu_y < HEAP_W) begin
					wr.len_we   = 1'b1;
					wr.free_we  = 1'b1;
					wr.free_val = 1'b1;
				end
			end
			S_WRP: begin
				waddr      = pos_q[AW-1:0];
				wlen       = need_q[AW-1:0];
				wr.len_we  = split_q;
				wr.free_we = 1'b1;
			end
			S_FREE: begin
				if (!neg && alu_y < HEAP_W) begin
					wr.free_we  = 1'b1;
					wr.free_val = 1'b1;
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= op ? S_FREE : S_NEED;
					end
				end
				S_NEED: state_q <= S_RD;
				S_RD:   state_q <= S_EV;
				S_EV: begin
					if (rd_len == '0) begin
						state_q <= S_DONE;
					end else if (rd_free && !neg) begin
						state_q <= S_SPL;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV:  state_q <= (alu_y > LAST_HD) ? S_DONE : S_RD;
				S_SPL:  state_q <= (!neg && alu_y != '0) ? S_NXT : S_WRP;
				S_NXT:  state_q <= S_WRP;
				S_WRP:  state_q <= S_DONE;
				S_FREE: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q     <= '0;
				addr_q    <= address;
				req_q     <= request_size;
				res_ok_q  <= 1'b0;
				res_off_q <= '0;
			end
			S_NEED: begin
				need_q <= alu_y[DW-1:0];
			end
			S_EV: begin
				len_q <= rd_len;
			end
			S_ADV: begin
				pos_q <= alu_y[PW-1:0];
			end
			S_SPL: begin
				split_q <= !neg && alu_y != '0;
				rem_q   <= alu_y[AW-1:0];
			end
			S_WRP: begin
				res_ok_q  <= 1'b1;
				res_off_q <= alu_y[11:0];
			end
			S_FREE: begin
				res_ok_q  <= 1'b1;
				res_off_q <= '0;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ok_q          <= res_ok_q;
					data_offset_q <= res_off_q;
				end
			end
			default: begin
				split_q <= split_q;
			end
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign data_offset = data_offset_q;

endmodule

[sv/ffha_chk.sv]
// Port-level checker for the allocator core, bound into the core module.
module ffha_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [11:0] data_offset
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(data_offset))
		else $error("result word changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> data_offset == 12'd0)
		else $error("failed allocate returned nonzero offset");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second word while busy");

endmodule

bind first_fit_heap_allocator_core ffha_chk u_ffha_chk (.*);
